[hdl/tmi_pkg.sv]
// ----------------------------------------------------------------------------
// tmi_pkg
// Shared types, constants and tables for the tone mixer / x4 interpolator:
// register indexes, sequencer states, Q1.17 filter taps and the cosine table.
// ----------------------------------------------------------------------------
package tmi_pkg;

  localparam int TAP_COUNT_DEF     = 127;
  localparam int HISTORY_DEPTH_DEF = 32;

  localparam int SAMPLE_W  = 16;
  localparam int LEVEL_W   = 16;
  localparam int STEP_W    = 31;
  localparam int PHASE_W   = 32;
  localparam int COEF_W    = 18;
  localparam int PROD_W    = COEF_W + SAMPLE_W;
  localparam int TAP_IDX_W = 9;
  localparam int COEF_LEN  = 127;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam int COS_ENTRIES = 256;
  localparam int COS_IDX_W   = $clog2(COS_ENTRIES);

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam int unsigned COS_DIVS [5] = '{90, 56, 30, 12, 2};

  // First half of the symmetric Q1.17 interpolation filter (taps 0..63)
  localparam int HALF_TAPS [64] = '{
    -260, 170, 170, 180, 183, 164, 115, 40,
    -53, -146, -220, -255, -238, -165, -45, 102,
    248, 360, 408, 373, 252, 60, -169, -391,
    -556, -621, -559, -369, -76, 269, 598, 837,
    925, 823, 532, 90, -425, -911, -1262, -1385,
    -1223, -777, -103, 685, 1433, 1978, 2172, 1922,
    1210, 113, -1205, -2505, -3510, -3946, -3591, -2316,
    -119, 2869, 6389, 10082, 13540, 16361, 18205, 18846
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TONE_ENABLE     = 2'd0,
    REG_TONE_LEVEL      = 2'd1,
    REG_TONE_PHASE_STEP = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TONE_MUL,
    S_TONE_MIX,
    S_MAC,
    S_DRAIN0,
    S_DRAIN1,
    S_EMIT
  } seq_state_t;

  typedef logic signed [SAMPLE_W-1:0] cos_table_t [COS_ENTRIES];

  // Tap j of the full 127-tap filter; zero past the end
  function automatic logic signed [COEF_W-1:0] tap_at(input logic [TAP_IDX_W-1:0] j);
    logic [TAP_IDX_W-1:0] k;
    k = TAP_IDX_W'(COEF_LEN - 1) - j;
    if (j >= TAP_IDX_W'(COEF_LEN)) begin
      return '0;
    end else if (j < TAP_IDX_W'(64)) begin
      return COEF_W'(HALF_TAPS[j[5:0]]);
    end else begin
      return COEF_W'(HALF_TAPS[k[5:0]]);
    end
  endfunction

  // Q1.15 cosine of table step idx: quadrant fold, Taylor series in Q30
  function automatic logic signed [SAMPLE_W-1:0] cos_entry(input int unsigned idx);
    logic [63:0] a;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] v;
    logic [63:0] s;
    logic [63:0] m;
    logic [1:0]  q;
    logic [15:0] r;
    int          i;
    a  = (64'(idx) << 32) / COS_ENTRIES;
    q  = a[31:30];
    x  = {34'd0, a[29:0]};
    y  = q[0] ? (Q30_ONE - x) : x;
    t  = (y * HALF_PI_Q30) >> 30;
    t2 = (t * t) >> 30;
    v  = Q30_ONE;
    for (i = 0; i < 5; i++) begin
      s = ((t2 * v) >> 30) / 64'(COS_DIVS[i[2:0]]);
      v = (s < Q30_ONE) ? (Q30_ONE - s) : 64'd0;
    end
    m = (v + 64'd16384) >> 15;
    if (m > 64'd32767) begin
      m = 64'd32767;
    end
    r = m[15:0];
    if (q == 2'd1 || q == 2'd2) begin
      return 16'(-r);
    end
    return r;
  endfunction

  function automatic cos_table_t build_cos_table();
    cos_table_t tab;
    int         i;
    for (i = 0; i < COS_ENTRIES; i++) begin
      tab[i[COS_IDX_W-1:0]] = cos_entry(i);
    end
    return tab;
  endfunction

  localparam cos_table_t COS_TABLE = build_cos_table();

endpackage

[hdl/tmi_hist_mem.sv]
// ----------------------------------------------------------------------------
// tmi_hist_mem
// Sample history ring storage: one write and one registered read per cycle.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module tmi_hist_mem #(
  parameter int DEPTH  = tmi_pkg::HISTORY_DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [ADDR_W-1:0]                   wr_addr,
  input  logic signed [tmi_pkg::SAMPLE_W-1:0] wr_data,
  input  logic                                rd_en,
  input  logic [ADDR_W-1:0]                   rd_addr,
  output logic signed [tmi_pkg::SAMPLE_W-1:0] rd_data
);
  import tmi_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           valid_r;
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic                       rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  // never-written slots read as zero
  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

[hdl/tone_mix_interpolate_by_four.sv]
// ----------------------------------------------------------------------------
// tone_mix_interpolate_by_four
// Adds a table-cosine tone to each 8 kHz voice word and produces four 32 kHz
// words from a polyphase 127-tap interpolation filter on one shared MAC.
// ----------------------------------------------------------------------------
// Input words are taken only in S_IDLE, once the fourth output word of the last
//   one is registered; phase p walks min(HISTORY_DEPTH, ceil((TAP_COUNT - p) / 4))
//   taps on the single 18x16 multiplier, which limits the rate. The first output
//   word is registered in S_EMIT after S_TONE_MUL, S_TONE_MIX, the phase-0 taps in
//   S_MAC, S_DRAIN0 and S_DRAIN1. Reset: synchronous active-low; clears state,
//   config, tone phase, ring position and all valid bits, with no clearing pass.
module tone_mix_interpolate_by_four #(
  parameter int TAP_COUNT     = tmi_pkg::TAP_COUNT_DEF,
  parameter int HISTORY_DEPTH = tmi_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [tmi_pkg::SAMPLE_W-1:0]   in_voice_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [tmi_pkg::SAMPLE_W-1:0]   out_dac_sample,
  output logic                                  out_last_of_four,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tmi_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tmi_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import tmi_pkg::*;

  localparam int HIST_W = $clog2(HISTORY_DEPTH);
  localparam int ACC_W  = PROD_W + HIST_W + 1;

  seq_state_t state_r, state_nxt;

  logic                       enable_r;
  logic [LEVEL_W-1:0]         level_cfg_r;
  logic [STEP_W-1:0]          step_r;
  logic [PHASE_W-1:0]         phase_r;

  logic signed [SAMPLE_W-1:0] voice_r;
  logic signed [SAMPLE_W-1:0] cos_r;
  logic [LEVEL_W-1:0]         level_r;
  logic [HIST_W-1:0]          wr_pos_r;
  logic [HIST_W-1:0]          rd_addr_r;
  logic [HIST_W-1:0]          m_r;
  logic [TAP_IDX_W-1:0]       j_r;
  logic [1:0]                 p_r;

  logic signed [COEF_W-1:0]   coef_r;
  logic                       issue_v_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic                       prod_v_r;
  logic signed [ACC_W-1:0]    acc_r;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_last_r;

  logic                       accept;
  logic                       issue;
  logic                       tone_sel;
  logic                       mix_we;
  logic                       emit_load;
  logic                       out_free;
  logic                       last_tap;

  logic signed [SAMPLE_W-1:0] hist_rd;
  logic signed [SAMPLE_W-1:0] cos_abs;
  logic signed [COEF_W-1:0]   mul_a;
  logic signed [SAMPLE_W-1:0] mul_b;
  logic [31:0]                tone_round;
  logic [17:0]                tone_mag;
  logic signed [18:0]         mix_sum;
  logic signed [SAMPLE_W-1:0] mix_sat;
  logic signed [ACC_W-1:0]    acc_rnd;
  logic signed [ACC_W-1:0]    acc_shift;
  logic signed [SAMPLE_W-1:0] acc_sat;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign last_tap  = ((j_r + TAP_IDX_W'(4)) >= TAP_IDX_W'(TAP_COUNT)) ||
                     (m_r == HIST_W'(HISTORY_DEPTH - 1));

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_TONE_MUL;
      S_TONE_MUL: state_nxt = S_TONE_MIX;
      S_TONE_MIX: state_nxt = S_MAC;
      S_MAC:      if (last_tap) state_nxt = S_DRAIN0;
      S_DRAIN0:   state_nxt = S_DRAIN1;
      S_DRAIN1:   state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_nxt = (p_r == 2'd3) ? S_IDLE : S_MAC;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    issue     = 1'b0;
    tone_sel  = 1'b0;
    mix_we    = 1'b0;
    emit_load = 1'b0;
    unique case (state_r)
      S_IDLE:     in_ready  = 1'b1;
      S_TONE_MUL: tone_sel  = 1'b1;
      S_TONE_MIX: mix_we    = 1'b1;
      S_MAC:      issue     = 1'b1;
      S_DRAIN0, S_DRAIN1: ;
      S_EMIT:     emit_load = out_free;
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- configuration and tone phase ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      level_cfg_r <= '0;
      step_r      <= '0;
      phase_r     <= '0;
    end else begin
      // use the phase, then advance it
      if (accept) begin
        phase_r <= phase_r + PHASE_W'(step_r);
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_TONE_ENABLE: enable_r    <= cfg_data[0];
          REG_TONE_LEVEL:  level_cfg_r <= cfg_data[LEVEL_W-1:0];
          REG_TONE_PHASE_STEP: begin
            step_r  <= cfg_data[STEP_W-1:0];
            phase_r <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      voice_r <= in_voice_sample;
      cos_r   <= COS_TABLE[phase_r[PHASE_W-1 -: COS_IDX_W]];
      level_r <= enable_r ? level_cfg_r : '0;
    end
  end

  // ---------------- tone mix ----------------
  assign cos_abs    = cos_r[SAMPLE_W-1] ? -cos_r : cos_r;
  assign tone_round = {1'b0, prod_r[30:0]} + 32'd8192;
  assign tone_mag   = tone_round[31:14];
  assign mix_sum    = cos_r[SAMPLE_W-1] ?
                      (19'(voice_r) - $signed({1'b0, tone_mag})) :
                      (19'(voice_r) + $signed({1'b0, tone_mag}));

  always_comb begin
    if (mix_sum > 19'sd32767) begin
      mix_sat = 16'sh7FFF;
    end else if (mix_sum < -19'sd32768) begin
      mix_sat = 16'sh8000;
    end else begin
      mix_sat = mix_sum[SAMPLE_W-1:0];
    end
  end

  tmi_hist_mem #(
    .DEPTH  (HISTORY_DEPTH),
    .ADDR_W (HIST_W)
  ) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mix_we),
    .wr_addr (wr_pos_r),
    .wr_data (mix_sat),
    .rd_en   (issue),
    .rd_addr (rd_addr_r),
    .rd_data (hist_rd)
  );

  // ---------------- tap walk ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r  <= '0;
      issue_v_r <= 1'b0;
      prod_v_r  <= 1'b0;
    end else begin
      issue_v_r <= issue;
      prod_v_r  <= issue_v_r;
      if (emit_load && p_r == 2'd3) begin
        wr_pos_r <= (wr_pos_r == HIST_W'(HISTORY_DEPTH - 1)) ? '0 : wr_pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_r       <= 2'd0;
      j_r       <= '0;
      m_r       <= '0;
      rd_addr_r <= wr_pos_r;
    end else if (issue) begin
      coef_r    <= tap_at(j_r);
      j_r       <= j_r + TAP_IDX_W'(4);
      m_r       <= m_r + 1'b1;
      rd_addr_r <= (rd_addr_r == '0) ? HIST_W'(HISTORY_DEPTH - 1) : rd_addr_r - 1'b1;
    end else if (emit_load) begin
      // restart the walk at the newest sample for the next phase
      p_r       <= p_r + 2'd1;
      j_r       <= TAP_IDX_W'(p_r) + TAP_IDX_W'(1);
      m_r       <= '0;
      rd_addr_r <= wr_pos_r;
    end
  end

  // ---------------- shared multiplier and accumulator ----------------
  assign mul_a = tone_sel ? COEF_W'($signed({1'b0, level_r})) : coef_r;
  assign mul_b = tone_sel ? cos_abs : hist_rd;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (accept || emit_load) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // Q2.32 sum times four back to Q1.15, round half up
  assign acc_rnd   = acc_r + ACC_W'(16384);
  assign acc_shift = acc_rnd >>> 15;

  always_comb begin
    if (acc_shift > ACC_W'(32767)) begin
      acc_sat = 16'sh7FFF;
    end else if (acc_shift < -ACC_W'(32768)) begin
      acc_sat = 16'sh8000;
    end else begin
      acc_sat = acc_shift[SAMPLE_W-1:0];
    end
  end

  // ---------------- output word register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_sample_r <= acc_sat;
      out_last_r   <= (p_r == 2'd3);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_dac_sample   = out_sample_r;
  assign out_last_of_four = out_last_r;

  // ---------------- checks ----------------
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("input accepted while previous word still in work");

  a_tone_mul_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TONE_MUL |-> $past(accept))
    else $error("tone multiply without an accepted word");

  a_no_mac_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !issue_v_r && !prod_v_r)
    else $error("accumulator pipeline active while idle");

  a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && out_valid_r && !out_ready |=> state_r == S_EMIT && out_valid_r)
    else $error("pending output word overwritten");

endmodule
